// ===== sv/masked_byte_pattern_search_top_defines.svh =====
// Assertion macros shared by the pattern search modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBPS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mbps_pkg.sv =====
`timescale 1ns / 1ps

package mbps_pkg;

	localparam int MBPS_MAX_PATTERN = 16;

	localparam int SEEN_W   = 32;
	localparam int ADDR_W   = 32;
	localparam int TOTAL_W  = 8;
	localparam int LEN_W    = 5;
	localparam int MASK_W   = 16;
	localparam int PAT_W    = 64;

	typedef enum logic {
		KIND_HIT     = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} in_word_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  hit_address;
		logic [TOTAL_W-1:0] hit_total;
		logic               last;
	} out_word_t;

	typedef struct packed {
		logic [PAT_W-1:0]   pattern_bytes_low;
		logic [PAT_W-1:0]   pattern_bytes_high;
		logic [MASK_W-1:0]  literal_mask;
		logic [LEN_W-1:0]   pattern_length;
		logic [ADDR_W-1:0]  region_base;
		logic [TOTAL_W-1:0] hit_cap;
	} cfg_t;

	// Words produced by one evaluated byte, oldest first.
	typedef struct packed {
		logic [1:0] count;
		out_word_t  first;
		out_word_t  second;
	} push_t;

endpackage

// ===== sv/mbps_window.sv =====
`timescale 1ns / 1ps

module mbps_window import mbps_pkg::*; #(
	parameter int MAX_PATTERN = MBPS_MAX_PATTERN
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  in_word_t                 in_word,
	output logic                     in_stall,
	input  logic                     adv,
	output logic                     valid_s1,
	output logic                     end_s1,
	output logic [MAX_PATTERN*8-1:0] win_s1,
	output logic [SEEN_W-1:0]        seen_s1
);

	logic [MAX_PATTERN*8-1:0] win_q;
	logic [MAX_PATTERN*8-1:0] shifted;
	logic [SEEN_W-1:0]        seen_q;
	logic [SEEN_W-1:0]        seen_inc;
	logic                     accept;

	// Byte zero of the window is the newest byte.
	always_comb begin
		shifted[7:0] = in_word.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			shifted[k*8 +: 8] = win_q[(k-1)*8 +: 8];
		end
	end

	assign seen_inc = (seen_q == '1) ? seen_q : seen_q + SEEN_W'(1);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			seen_q   <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (in_word.region_end) begin
				win_q  <= '0;
				seen_q <= '0;
			end else begin
				win_q  <= shifted;
				seen_q <= seen_inc;
			end
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1  <= shifted;
			seen_s1 <= seen_inc;
			end_s1  <= in_word.region_end;
		end
	end

endmodule

// ===== sv/mbps_match.sv =====
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_top_defines.svh"

module mbps_match import mbps_pkg::*; #(
	parameter int MAX_PATTERN = MBPS_MAX_PATTERN
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     adv,
	input  logic                     end_s1,
	input  logic [MAX_PATTERN*8-1:0] win_s1,
	input  logic [SEEN_W-1:0]        seen_s1,
	output push_t                    push
);

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

	logic [TOTAL_W-1:0]   hits_q;
	logic [TOTAL_W-1:0]   hits_inc;
	logic [TOTAL_W-1:0]   cap_eff;
	logic [LEN_W-1:0]     len_eff;
	logic [2*PAT_W-1:0]   pattern;
	logic [IDX_W-1:0]     idx;
	logic                 all_ok;
	logic                 hit;
	out_word_t            hit_w;
	out_word_t            sum_w;

	assign len_eff  = (cfg.pattern_length > MaxLen) ? MaxLen : cfg.pattern_length;
	assign cap_eff  = (cfg.hit_cap == '0) ? TOTAL_W'(1) : cfg.hit_cap;
	assign pattern  = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};
	assign hits_inc = hits_q + TOTAL_W'(1);

	// Pattern byte k lines up with the window byte that arrived len-1-k bytes ago.
	always_comb begin
		all_ok = 1'b1;
		idx    = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if ((LEN_W'(k) < len_eff) && cfg.literal_mask[k]) begin
				idx = IDX_W'(len_eff - LEN_W'(1) - LEN_W'(k));
				if (win_s1[idx*8 +: 8] != pattern[k*8 +: 8]) begin
					all_ok = 1'b0;
				end
			end
		end
	end

	assign hit = (len_eff != '0) && (seen_s1 >= SEEN_W'(len_eff)) &&
		(hits_q < cap_eff) && all_ok;

	always_comb begin
		hit_w.kind        = KIND_HIT;
		hit_w.hit_address = cfg.region_base + seen_s1 - ADDR_W'(len_eff);
		hit_w.hit_total   = hits_inc;
		hit_w.last        = !end_s1;

		sum_w.kind        = KIND_SUMMARY;
		sum_w.hit_address = '0;
		sum_w.hit_total   = hit ? hits_inc : hits_q;
		sum_w.last        = 1'b1;

		push.count  = adv ? (2'(hit) + 2'(end_s1)) : 2'd0;
		push.first  = hit ? hit_w : sum_w;
		push.second = sum_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (adv) begin
			if (end_s1) begin
				hits_q <= '0;
			end else if (hit) begin
				hits_q <= hits_inc;
			end
		end
	end

	`MBPS_ASSERT_NEXT(a_hits_clear, adv && end_s1, hits_q == '0, "hit count not cleared after region end")

endmodule

// ===== sv/mbps_out_queue.sv =====
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_top_defines.svh"

module mbps_out_queue import mbps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	input  logic      out_stall,
	output logic      out_valid,
	output out_word_t out_word,
	output logic      can_take
);

	logic [1:0] cnt_q;
	logic [1:0] rem;
	logic [1:0] cnt_d;
	logic       pop;
	out_word_t  slot_q [2];
	out_word_t  keep;
	out_word_t  nxt0;
	out_word_t  nxt1;

	assign out_valid = (cnt_q != 2'd0);
	assign out_word  = slot_q[0];
	assign pop       = out_valid && !out_stall;

	// A new byte may be evaluated only when the queue will be empty after this edge,
	// so both words of an end byte always fit.
	assign can_take = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall);

	always_comb begin
		rem   = cnt_q - 2'(pop);
		keep  = pop ? slot_q[1] : slot_q[0];
		cnt_d = rem + push.count;
		if (rem == 2'd0) begin
			nxt0 = push.first;
			nxt1 = push.second;
		end else if (rem == 2'd1) begin
			nxt0 = keep;
			nxt1 = push.first;
		end else begin
			nxt0 = slot_q[0];
			nxt1 = slot_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= nxt0;
		slot_q[1] <= nxt1;
	end

	`MBPS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= 2'd2, "output queue overfilled")
	`MBPS_ASSERT_IMPL(a_push_room, push.count != 2'd0, can_take, "words pushed without room")

endmodule

// ===== sv/masked_byte_pattern_search_top.sv =====
// Masked byte pattern search: one region byte per word, hits and summaries out.
// Throughput: one byte per cycle while the output is not stalled; an end byte
// that also hits yields two words and holds the input stage while both drain
// through the queue.
// Reset (arst_n low, asynchronous) clears the window, counters, queue and config
// to pattern length 1, hit cap 2 and zero elsewhere.
`timescale 1ns / 1ps
`include "masked_byte_pattern_search_top_defines.svh"

module masked_byte_pattern_search_top import mbps_pkg::*; #(
	parameter int MAX_PATTERN = MBPS_MAX_PATTERN
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [PAT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_word
);

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_PAT_LO   = 3'd0,
		CFG_PAT_HI   = 3'd1,
		CFG_MASK     = 3'd2,
		CFG_LENGTH   = 3'd3,
		CFG_BASE     = 3'd4,
		CFG_HIT_CAP  = 3'd5
	} cfg_idx_t;

	cfg_t                     cfg_q;
	logic                     valid_s1;
	logic                     end_s1;
	logic [MAX_PATTERN*8-1:0] win_s1;
	logic [SEEN_W-1:0]        seen_s1;
	logic                     can_take;
	logic                     adv;
	push_t                    push;

	// The user must write configuration registers only while the block is idle, so a
	// write never lands between a byte and its results; the block does not check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes_low  <= '0;
			cfg_q.pattern_bytes_high <= '0;
			cfg_q.literal_mask       <= '0;
			cfg_q.pattern_length     <= LEN_W'(1);
			cfg_q.region_base        <= '0;
			cfg_q.hit_cap            <= TOTAL_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAT_LO:  cfg_q.pattern_bytes_low  <= cfg_data;
				CFG_PAT_HI:  cfg_q.pattern_bytes_high <= cfg_data;
				CFG_MASK:    cfg_q.literal_mask       <= cfg_data[MASK_W-1:0];
				CFG_LENGTH:  cfg_q.pattern_length     <= cfg_data[LEN_W-1:0];
				CFG_BASE:    cfg_q.region_base        <= cfg_data[ADDR_W-1:0];
				CFG_HIT_CAP: cfg_q.hit_cap            <= cfg_data[TOTAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The evaluation stage moves forward whenever the output queue can take both
	// words of the byte it holds. The input register takes a new byte in the same
	// cycle, so a free-flowing stream runs at one byte per clock.
	assign adv = valid_s1 && can_take;

	// Input stage: keeps the sliding window and byte count, and registers a copy
	// of the shifted window for the compare.
	mbps_window #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_word  (in_word),
		.in_stall (in_stall),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.end_s1   (end_s1),
		.win_s1   (win_s1),
		.seen_s1  (seen_s1)
	);

	// Compare stage: every pattern position is checked in parallel, the hit
	// count is kept here, and the hit and summary words are formed.
	mbps_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.adv     (adv),
		.end_s1  (end_s1),
		.win_s1  (win_s1),
		.seen_s1 (seen_s1),
		.push    (push)
	);

	// Two-word result queue that decouples the output handshake from the stages.
	mbps_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word),
		.can_take  (can_take)
	);

	`MBPS_ASSERT_IMPL(a_sum_addr, out_valid && (out_word.kind == KIND_SUMMARY), out_word.hit_address == '0 && out_word.last, "summary word malformed")
	`MBPS_ASSERT_IMPL(a_hit_total, out_valid && (out_word.kind == KIND_HIT), out_word.hit_total != '0, "hit word with zero total")

endmodule
